// ===== rtl/core/mono_framebuffer_diff_flush_unit_defines.svh =====
// Assertion macros used by the checker file of the frame buffer unit.
`ifndef MONO_FRAMEBUFFER_DIFF_FLUSH_UNIT_DEFINES_SVH
`define MONO_FRAMEBUFFER_DIFF_FLUSH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MFDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define MFDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/mfdf_pkg.sv =====
package mfdf_pkg;

	// Operation codes
	localparam logic [2:0] OP_DRAW      = 3'd0;
	localparam logic [2:0] OP_READ_PX   = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_DIFF      = 3'd3;
	localparam logic [2:0] OP_FULL      = 3'd4;
	localparam logic [2:0] OP_READ_BYTE = 3'd5;

	// Pixel colors
	localparam logic [1:0] COLOR_BLACK       = 2'd0;
	localparam logic [1:0] COLOR_WHITE       = 2'd1;
	localparam logic [1:0] COLOR_INVERT      = 2'd2;
	localparam logic [1:0] COLOR_TRANSPARENT = 2'd3;

	// Result kinds
	localparam logic [2:0] KIND_ACK   = 3'd0;
	localparam logic [2:0] KIND_PIXEL = 3'd1;
	localparam logic [2:0] KIND_BYTE  = 3'd2;
	localparam logic [2:0] KIND_NONE  = 3'd3;
	localparam logic [2:0] KIND_SPAN  = 3'd4;

	// Frame geometry
	localparam int         NUM_PAGES      = 8;
	localparam int         FLUSH_COLS_MAX = 128;
	localparam logic [2:0] LAST_PAGE      = 3'd7;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [1:0]         color;
		logic [2:0]         page;
		logic [6:0]         column;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       pixel;
		logic [7:0] data_byte;
		logic [2:0] span_page;
		logic [6:0] first_col;
		logic [6:0] last_col;
		logic       last;
	} rsp_t;

	// Source of a pushed result
	typedef enum logic [1:0] {
		PUSH_ITEM = 2'd0,
		PUSH_PEND = 2'd1,
		PUSH_FULL = 2'd2
	} push_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      cnt_wide;
		logic      pg_inc;
		logic      rd_sweep;
		logic      wr_px;
		logic      wr_cur_zero;
		logic      wr_pri_zero;
		logic      copy_rd;
		logic      cmp;
		logic      page_done;
		logic      pend_clr;
		logic      push;
		push_sel_t push_sel;
		logic      push_last;
		logic      set_flag;
		logic      clr_flag;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic col_end;
		logic sweep_last;
		logic last_page;
		logic found;
		logic pend_vld;
		logic flag;
		logic draw_hit;
		logic is_full;
	} stat_t;

endpackage

// ===== rtl/core/mfdf_ctrl.sv =====
module mfdf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic [2:0]          op,
	output logic                cmd_stall,
	input  mfdf_pkg::stat_t     stat,
	output mfdf_pkg::ctl_t      ctl
);

	typedef enum logic [12:0] {
		ST_INIT      = 13'b0000000000001,
		ST_IDLE      = 13'b0000000000010,
		ST_PX_RD     = 13'b0000000000100,
		ST_PX_DONE   = 13'b0000000001000,
		ST_RESP      = 13'b0000000010000,
		ST_CLEAR     = 13'b0000000100000,
		ST_SCAN_RD   = 13'b0000001000000,
		ST_SCAN_CMP  = 13'b0000010000000,
		ST_SCAN_PAGE = 13'b0000100000000,
		ST_DIFF_END  = 13'b0001000000000,
		ST_COPY      = 13'b0010000000000,
		ST_COPY_WAIT = 13'b0100000000000,
		ST_FULL_EMIT = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode state into datapath commands
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				ctl.wr_cur_zero = 1'b1;
				ctl.wr_pri_zero = 1'b1;
				ctl.cnt_inc     = 1'b1;
				ctl.cnt_wide    = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load    = 1'b1;
					ctl.cnt_clr = 1'b1;
					unique case (op) inside
						mfdf_pkg::OP_DRAW, mfdf_pkg::OP_READ_PX, mfdf_pkg::OP_READ_BYTE: begin
							state_d = ST_PX_RD;
						end
						mfdf_pkg::OP_CLEAR: begin
							state_d = ST_CLEAR;
						end
						mfdf_pkg::OP_DIFF: begin
							if (stat.flag) begin
								ctl.clr_flag = 1'b1;
								ctl.pend_clr = 1'b1;
								state_d      = ST_SCAN_RD;
							end else begin
								state_d = ST_RESP;
							end
						end
						mfdf_pkg::OP_FULL: begin
							ctl.clr_flag = 1'b1;
							state_d      = ST_COPY;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_PX_RD: begin
				state_d = ST_PX_DONE;
			end
			ST_PX_DONE: begin
				// Write back and answer together once the output slot frees
				if (stat.out_free) begin
					ctl.push      = 1'b1;
					ctl.push_sel  = mfdf_pkg::PUSH_ITEM;
					ctl.push_last = 1'b1;
					if (stat.draw_hit) begin
						ctl.wr_px    = 1'b1;
						ctl.set_flag = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					ctl.push      = 1'b1;
					ctl.push_sel  = mfdf_pkg::PUSH_ITEM;
					ctl.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				ctl.wr_cur_zero = 1'b1;
				ctl.cnt_inc     = 1'b1;
				ctl.cnt_wide    = 1'b1;
				if (stat.sweep_last) begin
					ctl.set_flag = 1'b1;
					state_d      = ST_RESP;
				end
			end
			ST_SCAN_RD: begin
				ctl.rd_sweep = 1'b1;
				state_d      = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				ctl.rd_sweep = 1'b1;
				ctl.cmp      = 1'b1;
				if (stat.col_end) begin
					state_d = ST_SCAN_PAGE;
				end else begin
					ctl.cnt_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_SCAN_PAGE: begin
				// Hold while an older span must leave but the output is full
				if (!(stat.found && stat.pend_vld && !stat.out_free)) begin
					ctl.page_done = 1'b1;
					ctl.cnt_inc   = 1'b1;
					if (stat.found && stat.pend_vld) begin
						ctl.push     = 1'b1;
						ctl.push_sel = mfdf_pkg::PUSH_PEND;
					end
					if (stat.sweep_last) begin
						state_d = ST_DIFF_END;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_DIFF_END: begin
				if (stat.out_free) begin
					ctl.push      = 1'b1;
					ctl.push_last = 1'b1;
					if (stat.pend_vld) begin
						ctl.push_sel = mfdf_pkg::PUSH_PEND;
						state_d      = ST_COPY;
					end else begin
						ctl.push_sel = mfdf_pkg::PUSH_ITEM;
						state_d      = ST_IDLE;
					end
				end
			end
			ST_COPY: begin
				ctl.rd_sweep = 1'b1;
				ctl.copy_rd  = 1'b1;
				ctl.cnt_inc  = 1'b1;
				ctl.cnt_wide = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_COPY_WAIT;
				end
			end
			ST_COPY_WAIT: begin
				// Last copy write lands in this cycle
				if (stat.is_full) begin
					state_d = ST_FULL_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FULL_EMIT: begin
				if (stat.out_free) begin
					ctl.push      = 1'b1;
					ctl.push_sel  = mfdf_pkg::PUSH_FULL;
					ctl.push_last = stat.last_page;
					ctl.pg_inc    = 1'b1;
					if (stat.last_page) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

// ===== rtl/core/mfdf_dp.sv =====
module mfdf_dp #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mfdf_pkg::cmd_t      cmd,
	input  mfdf_pkg::ctl_t      ctl,
	output mfdf_pkg::stat_t     stat,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output mfdf_pkg::rsp_t      rsp
);

	localparam int FLUSH_COLS  = (DISPLAY_WIDTH < mfdf_pkg::FLUSH_COLS_MAX) ?
		DISPLAY_WIDTH : mfdf_pkg::FLUSH_COLS_MAX;
	localparam int FRAME_BYTES = DISPLAY_WIDTH * mfdf_pkg::NUM_PAGES;
	localparam int AW          = $clog2(FRAME_BYTES);
	localparam int CW          = $clog2(DISPLAY_WIDTH);
	localparam int RW          = $clog2(DISPLAY_HEIGHT);

	mfdf_pkg::cmd_t item_q;

	logic          x_in;
	logic          y_in;
	logic          on_screen;
	logic [CW-1:0] cx;
	logic [RW-1:0] ry;
	logic [RW-1:0] sr;
	logic [2:0]    px_page;
	logic [2:0]    bit_idx;
	logic [7:0]    mask;
	logic [AW-1:0] px_addr;
	logic          byte_ok;
	logic [AW-1:0] byte_addr;
	logic [AW-1:0] item_addr;

	logic [2:0]    pg_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] col_lim;
	logic          col_end;
	logic [AW-1:0] sweep_addr;
	logic [AW-1:0] rd_addr;

	logic [7:0]    cur_mem [FRAME_BYTES];
	logic [7:0]    pri_mem [FRAME_BYTES];
	logic [7:0]    cur_rd_q;
	logic [7:0]    pri_rd_q;
	logic [7:0]    new_byte;
	logic          copy_s1;
	logic [AW-1:0] addr_s1;

	logic          flag_q;
	logic          diff;
	logic          found_q;
	logic [6:0]    first_q;
	logic [6:0]    last_q;
	logic          pend_vld_q;
	logic [2:0]    pend_page_q;
	logic [6:0]    pend_first_q;
	logic [6:0]    pend_last_q;

	mfdf_pkg::rsp_t rsp_nxt;
	mfdf_pkg::rsp_t rsp_q;
	logic           rsp_vld_q;
	logic           out_free;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
	end

	// Clip, rotate and interleave the pixel coordinates
	always_comb begin
		x_in      = (item_q.x >= 0) && (int'(item_q.x) < DISPLAY_WIDTH);
		y_in      = (item_q.y >= 0) && (int'(item_q.y) < DISPLAY_HEIGHT);
		on_screen = x_in && y_in;
		cx        = CW'(DISPLAY_WIDTH - 1) - item_q.x[CW-1:0];
		ry        = RW'(DISPLAY_HEIGHT - 1) - item_q.y[RW-1:0];
		sr        = (ry >> 1) + (ry[0] ? RW'(DISPLAY_HEIGHT / 2) : '0);
		px_page   = 3'(sr >> 3);
		bit_idx   = sr[2:0];
		mask      = 8'b1 << bit_idx;
		px_addr   = on_screen ? AW'(int'(px_page) * DISPLAY_WIDTH + int'(cx)) : '0;
		byte_ok   = int'(item_q.column) < DISPLAY_WIDTH;
		byte_addr = byte_ok ?
			AW'(int'(item_q.page) * DISPLAY_WIDTH + int'(item_q.column)) : '0;
		item_addr = (item_q.op == mfdf_pkg::OP_READ_BYTE) ? byte_addr : px_addr;
	end

	// Step the page and column sweep counter
	assign col_lim    = ctl.cnt_wide ? CW'(DISPLAY_WIDTH - 1) : CW'(FLUSH_COLS - 1);
	assign col_end    = (col_q == col_lim);
	assign sweep_addr = AW'(int'(pg_q) * DISPLAY_WIDTH + int'(col_q));
	assign rd_addr    = ctl.rd_sweep ? sweep_addr : item_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q  <= '0;
			col_q <= '0;
		end else if (ctl.cnt_clr) begin
			pg_q  <= '0;
			col_q <= '0;
		end else if (ctl.cnt_inc) begin
			if (col_end) begin
				col_q <= '0;
				pg_q  <= pg_q + 3'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (ctl.pg_inc) begin
			pg_q <= pg_q + 3'd1;
		end
	end

	// Apply the drawing color to the fetched byte
	always_comb begin
		case (item_q.color)
			mfdf_pkg::COLOR_WHITE: new_byte = cur_rd_q | mask;
			mfdf_pkg::COLOR_BLACK: new_byte = cur_rd_q & ~mask;
			default:               new_byte = cur_rd_q ^ mask;
		endcase
	end

	// Current frame memory
	always_ff @(posedge clk) begin
		if (ctl.wr_px) begin
			cur_mem[px_addr] <= new_byte;
		end else if (ctl.wr_cur_zero) begin
			cur_mem[sweep_addr] <= '0;
		end
		cur_rd_q <= cur_mem[rd_addr];
	end

	// Prior frame memory, written in the cycle after each current frame read
	always_ff @(posedge clk) begin
		if (ctl.wr_pri_zero) begin
			pri_mem[sweep_addr] <= '0;
		end else if (copy_s1) begin
			pri_mem[addr_s1] <= cur_rd_q;
		end
		pri_rd_q <= pri_mem[sweep_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_s1 <= 1'b0;
		end else begin
			copy_s1 <= ctl.copy_rd;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= sweep_addr;
	end

	// Changed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.set_flag) begin
			flag_q <= 1'b1;
		end else if (ctl.clr_flag) begin
			flag_q <= 1'b0;
		end
	end

	// Track the first and last differing column of the page under scan
	assign diff = (cur_rd_q != pri_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.pend_clr || ctl.page_done) begin
			found_q <= 1'b0;
		end else if (ctl.cmp && diff) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp && diff) begin
			if (!found_q) begin
				first_q <= 7'(col_q);
			end
			last_q <= 7'(col_q);
		end
	end

	// Hold one span back so the final one can carry the last mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (ctl.pend_clr) begin
			pend_vld_q <= 1'b0;
		end else if (ctl.page_done && found_q) begin
			pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.page_done && found_q) begin
			pend_page_q  <= pg_q;
			pend_first_q <= first_q;
			pend_last_q  <= last_q;
		end
	end

	// Build the result to push
	always_comb begin
		rsp_nxt      = '0;
		rsp_nxt.last = ctl.push_last;
		unique case (ctl.push_sel)
			mfdf_pkg::PUSH_ITEM: begin
				case (item_q.op)
					mfdf_pkg::OP_READ_PX: begin
						rsp_nxt.kind  = mfdf_pkg::KIND_PIXEL;
						rsp_nxt.pixel = on_screen & cur_rd_q[bit_idx];
					end
					mfdf_pkg::OP_READ_BYTE: begin
						rsp_nxt.kind      = mfdf_pkg::KIND_BYTE;
						rsp_nxt.data_byte = byte_ok ? cur_rd_q : '0;
					end
					mfdf_pkg::OP_DIFF: begin
						rsp_nxt.kind = mfdf_pkg::KIND_NONE;
					end
					default: begin
						rsp_nxt.kind = mfdf_pkg::KIND_ACK;
					end
				endcase
			end
			mfdf_pkg::PUSH_PEND: begin
				rsp_nxt.kind      = mfdf_pkg::KIND_SPAN;
				rsp_nxt.span_page = pend_page_q;
				rsp_nxt.first_col = pend_first_q;
				rsp_nxt.last_col  = pend_last_q;
			end
			mfdf_pkg::PUSH_FULL: begin
				rsp_nxt.kind      = mfdf_pkg::KIND_SPAN;
				rsp_nxt.span_page = pg_q;
				rsp_nxt.first_col = '0;
				rsp_nxt.last_col  = 7'(FLUSH_COLS - 1);
			end
			default: begin
				rsp_nxt.kind = mfdf_pkg::KIND_ACK;
			end
		endcase
	end

	// Output register: load on push, drop once taken
	assign out_free = !rsp_vld_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (ctl.push) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Report status
	always_comb begin
		stat            = '0;
		stat.out_free   = out_free;
		stat.col_end    = col_end;
		stat.last_page  = (pg_q == mfdf_pkg::LAST_PAGE);
		stat.sweep_last = col_end && (pg_q == mfdf_pkg::LAST_PAGE);
		stat.found      = found_q;
		stat.pend_vld   = pend_vld_q;
		stat.flag       = flag_q;
		stat.draw_hit   = (item_q.op == mfdf_pkg::OP_DRAW) &&
			(item_q.color != mfdf_pkg::COLOR_TRANSPARENT) && on_screen;
		stat.is_full    = (item_q.op == mfdf_pkg::OP_FULL);
	end

endmodule

// ===== rtl/core/mono_framebuffer_diff_flush_unit.sv =====
// Monochrome page frame buffer with dirty-region flush. Items enter on the
// cmd channel only while cmd_stall is low; results leave through a one-entry
// output register on rsp, so the next item is taken while a result waits.
// Per item (B = DISPLAY_WIDTH * 8 bytes, F = min(DISPLAY_WIDTH, 128) flushed
// columns per page): pixel draw, pixel read and byte read fetch the byte and
// then answer, a draw writing the byte back as it answers; clear zeroes all
// B bytes of the current frame; a diff flush with the changed flag clear
// answers with no span; a diff flush with the flag set compares both frames
// byte by byte over the F flushed columns of each page, emits a span for each
// page that differs, and copies the frame when some column differs; a full
// flush copies all B bytes and then emits its eight page spans, one a cycle
// while the output register is free. A result that must be pushed while the
// output register holds a stalled result waits until that one is taken.
// After reset both frames are cleared, during which cmd_stall stays high.
module mono_framebuffer_diff_flush_unit #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  mfdf_pkg::cmd_t     cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output mfdf_pkg::rsp_t     rsp
);

	mfdf_pkg::ctl_t  ctl;
	mfdf_pkg::stat_t stat;

	// Sequence each item
	mfdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.op        (cmd.op),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Frames, sweep counter, span tracking and output register
	mfdf_dp #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/mfdf_chk.sv =====
`include "mono_framebuffer_diff_flush_unit_defines.svh"

module mfdf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input mfdf_pkg::rsp_t rsp
);

	// A stalled result stays offered
	`MFDF_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)
	// A stalled result keeps its payload
	`MFDF_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(rsp))
	// Accepting an item makes the block busy
	`MFDF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)
	// No new item while an item still owes results
	`MFDF_ASSERT_IMP(a_busy_until_last, clk, arst_n, rsp_valid && !rsp.last, cmd_stall)

endmodule

bind mono_framebuffer_diff_flush_unit mfdf_chk u_mfdf_chk (.*);
